// ===== rtl/core/rfc_pkg.sv =====
package rfc_pkg;

  // Default sizes
  localparam int unsigned MAX_LEN_DEF   = 64;
  localparam int unsigned MAX_RAILS_DEF = 16;

  // Field widths
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned RC_W   = 5;

  // Configuration port
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;

  // Register indexes (paddr bit 2)
  localparam logic REG_RAIL_COUNT   = 1'b0;
  localparam logic REG_DECRYPT_MODE = 1'b1;

  // Register reset values
  localparam logic [RC_W-1:0] RAIL_COUNT_RST   = 5'd3;
  localparam logic            DECRYPT_MODE_RST = 1'b0;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GATHER,
    ST_SCATTER,
    ST_EMIT
  } rfc_state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic gen_step;
    logic emit_step;
  } rfc_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic gen_done;
    logic emit_done;
  } rfc_sts_t;

endpackage

// ===== rtl/core/rfc_ram.sv =====
module rfc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/rfc_ctrl.sv =====
module rfc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                in_last_i,
  input  logic                decrypt_i,
  input  rfc_pkg::rfc_sts_t   sts_i,
  output rfc_pkg::rfc_cmd_t   cmd_o,
  output logic                busy_o
);

  rfc_pkg::rfc_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rfc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rfc_pkg::ST_IDLE: begin
        if (start_i && in_last_i) begin
          state_d = decrypt_i ? rfc_pkg::ST_SCATTER : rfc_pkg::ST_GATHER;
        end
      end
      rfc_pkg::ST_GATHER: begin
        if (sts_i.gen_done) state_d = rfc_pkg::ST_IDLE;
      end
      rfc_pkg::ST_SCATTER: begin
        if (sts_i.gen_done) state_d = rfc_pkg::ST_EMIT;
      end
      rfc_pkg::ST_EMIT: begin
        if (sts_i.emit_done) state_d = rfc_pkg::ST_IDLE;
      end
      default: state_d = rfc_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    unique case (state_q)
      rfc_pkg::ST_IDLE: begin
        busy_o     = 1'b0;
        cmd_o.load = start_i;
      end
      rfc_pkg::ST_GATHER, rfc_pkg::ST_SCATTER: begin
        cmd_o.gen_step = !sts_i.gen_done;
      end
      rfc_pkg::ST_EMIT: begin
        cmd_o.emit_step = !sts_i.emit_done;
      end
      default: busy_o = 1'b1;
    endcase
  end

endmodule

// ===== rtl/core/rfc_dpath.sv =====
module rfc_dpath #(
  parameter int unsigned MaxLen   = rfc_pkg::MAX_LEN_DEF,
  parameter int unsigned MaxRails = rfc_pkg::MAX_RAILS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  rfc_pkg::rfc_cmd_t         cmd_i,
  output rfc_pkg::rfc_sts_t         sts_o,
  input  logic [rfc_pkg::BYTE_W-1:0] in_byte_i,
  input  logic                      in_last_i,
  input  logic [rfc_pkg::RC_W-1:0]  rail_count_i,
  input  logic                      decrypt_i,
  output logic                      out_valid_o,
  output logic [rfc_pkg::BYTE_W-1:0] out_byte_o,
  output logic                      out_last_o,
  output logic                      overflow_o
);

  localparam int unsigned AW = $clog2(MaxLen);
  localparam int unsigned CW = $clog2(MaxLen + 1);
  localparam int unsigned KW = $clog2(MaxRails + 1);
  localparam int unsigned RW = $clog2(MaxRails);
  localparam int unsigned PW = $clog2(MaxLen + 2 * MaxRails);

  logic [CW-1:0] cnt_q, len_q, rank_q, seq_q;
  logic [KW-1:0] k_q, k_d;
  logic [RW-1:0] rail_q;
  logic [PW-1:0] pos_q, step, k1, rail_x;
  logic          phase_q, mode_q, ovf_seen_q, ovf_out_q;
  logic          full, yield, accept_last;
  logic          sc_vld_q;
  logic [AW-1:0] sc_addr_q;
  logic          ov_q, olast_q;
  logic [rfc_pkg::BYTE_W-1:0] buf_rdata, work_rdata;

  assign full        = (cnt_q == CW'(MaxLen));
  assign accept_last = cmd_i.load && in_last_i;
  assign yield       = cmd_i.gen_step && (pos_q < PW'(len_q));

  // Clamp the rail count to 1..MaxRails
  always_comb begin
    if (rail_count_i == '0) begin
      k_d = KW'(1);
    end else if (32'(rail_count_i) > 32'(MaxRails)) begin
      k_d = KW'(MaxRails);
    end else begin
      k_d = KW'(rail_count_i);
    end
  end

  // Zigzag stride along the current rail
  assign k1     = PW'(k_q) - PW'(1);
  assign rail_x = PW'(rail_q);
  always_comb begin
    if (k_q == KW'(1)) begin
      step = PW'(1);
    end else if (rail_q == '0 || rail_x == k1) begin
      step = k1 << 1;
    end else if (phase_q) begin
      step = rail_x << 1;
    end else begin
      step = (k1 - rail_x) << 1;
    end
  end

  // Message length, overflow and latched run settings
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      len_q      <= '0;
      k_q        <= KW'(1);
      mode_q     <= 1'b0;
      ovf_seen_q <= 1'b0;
      ovf_out_q  <= 1'b0;
    end else if (cmd_i.load) begin
      if (in_last_i) begin
        len_q      <= full ? cnt_q : cnt_q + CW'(1);
        k_q        <= k_d;
        mode_q     <= decrypt_i;
        ovf_out_q  <= ovf_seen_q | full;
        cnt_q      <= '0;
        ovf_seen_q <= 1'b0;
      end else if (full) begin
        ovf_seen_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q + CW'(1);
      end
    end
  end

  // Walk rails and positions in rail order
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rail_q  <= '0;
      pos_q   <= '0;
      phase_q <= 1'b0;
      rank_q  <= '0;
    end else if (accept_last) begin
      rail_q  <= '0;
      pos_q   <= '0;
      phase_q <= 1'b0;
      rank_q  <= '0;
    end else if (cmd_i.gen_step) begin
      if (yield) begin
        pos_q   <= pos_q + step;
        phase_q <= !phase_q;
        rank_q  <= rank_q + CW'(1);
      end else begin
        rail_q  <= rail_q + RW'(1);
        pos_q   <= PW'(rail_q) + PW'(1);
        phase_q <= 1'b0;
      end
    end
  end

  // Sequential index for the decrypt output pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q <= '0;
    end else if (accept_last) begin
      seq_q <= '0;
    end else if (cmd_i.emit_step) begin
      seq_q <= seq_q + CW'(1);
    end
  end

  // Scatter pipeline and output strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_vld_q <= 1'b0;
      ov_q     <= 1'b0;
      olast_q  <= 1'b0;
    end else begin
      sc_vld_q <= yield && mode_q;
      ov_q     <= (yield && !mode_q) || cmd_i.emit_step;
      olast_q  <= cmd_i.emit_step ? (seq_q == len_q - CW'(1))
                                  : (rank_q == len_q - CW'(1));
    end
  end

  always_ff @(posedge clk_i) begin
    sc_addr_q <= pos_q[AW-1:0];
  end

  // Message buffer: gather at the zigzag position, or read in rank order
  rfc_ram #(
    .Width (rfc_pkg::BYTE_W),
    .Depth (MaxLen)
  ) u_msg_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load && !full),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i (in_byte_i),
    .raddr_i (mode_q ? rank_q[AW-1:0] : pos_q[AW-1:0]),
    .rdata_o (buf_rdata)
  );

  // Work buffer: scatter ciphertext bytes to their plaintext positions
  rfc_ram #(
    .Width (rfc_pkg::BYTE_W),
    .Depth (MaxLen)
  ) u_work_ram (
    .clk_i   (clk_i),
    .we_i    (sc_vld_q),
    .waddr_i (sc_addr_q),
    .wdata_i (buf_rdata),
    .raddr_i (seq_q[AW-1:0]),
    .rdata_o (work_rdata)
  );

  assign sts_o.gen_done  = (rank_q == len_q);
  assign sts_o.emit_done = (seq_q == len_q);

  assign out_valid_o = ov_q;
  assign out_byte_o  = mode_q ? work_rdata : buf_rdata;
  assign out_last_o  = olast_q;
  assign overflow_o  = ovf_out_q;

endmodule

// ===== rtl/core/rail_fence_cipher.sv =====
// Channel  | Signals                                         | Direction
// ---------+-------------------------------------------------+----------
// input    | start, busy, in_byte_i, in_last_i               | in/out
// result   | out_valid_o, out_byte_o, out_last_o, overflow_o | out
// config   | psel, penable, pwrite, paddr, pwdata, prdata,   | in/out
//          | pready                                          |
//
// Bytes load one per cycle while busy is low and start is high. After the last
// byte of an n-byte message with k effective rails, encrypt keeps busy high
// for a walk that reads one byte per step, changes rail when a rail runs out
// and then finishes; the n results trail their buffer reads through the
// registered RAM read port. Decrypt keeps busy high for a scatter pass, then a
// sequential read pass that carries the n results. Reset clears control state
// and loads the register defaults; buffer contents are not cleared. Results
// are one-cycle strobes and the receiver cannot stall them.
module rail_fence_cipher #(
  parameter int unsigned MaxLen   = rfc_pkg::MAX_LEN_DEF,
  parameter int unsigned MaxRails = rfc_pkg::MAX_RAILS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [rfc_pkg::BYTE_W-1:0]  in_byte_i,
  input  logic                        in_last_i,
  output logic                        out_valid_o,
  output logic [rfc_pkg::BYTE_W-1:0]  out_byte_o,
  output logic                        out_last_o,
  output logic                        overflow_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rfc_pkg::APB_AW-1:0]  paddr,
  input  logic [rfc_pkg::APB_DW-1:0]  pwdata,
  output logic [rfc_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);

  logic [rfc_pkg::RC_W-1:0] rail_count_q;
  logic                     decrypt_mode_q;
  logic                     cfg_we;
  rfc_pkg::rfc_cmd_t        cmd;
  rfc_pkg::rfc_sts_t        sts;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rail_count_q   <= rfc_pkg::RAIL_COUNT_RST;
      decrypt_mode_q <= rfc_pkg::DECRYPT_MODE_RST;
    end else if (cfg_we) begin
      unique case (paddr[2])
        rfc_pkg::REG_RAIL_COUNT:   rail_count_q   <= pwdata[rfc_pkg::RC_W-1:0];
        rfc_pkg::REG_DECRYPT_MODE: decrypt_mode_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    unique case (paddr[2])
      rfc_pkg::REG_RAIL_COUNT:   prdata = rfc_pkg::APB_DW'(rail_count_q);
      rfc_pkg::REG_DECRYPT_MODE: prdata = rfc_pkg::APB_DW'(decrypt_mode_q);
      default:                   prdata = '0;
    endcase
  end

  rfc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .in_last_i (in_last_i),
    .decrypt_i (decrypt_mode_q),
    .sts_i     (sts),
    .cmd_o     (cmd),
    .busy_o    (busy)
  );

  rfc_dpath #(
    .MaxLen   (MaxLen),
    .MaxRails (MaxRails)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_byte_i    (in_byte_i),
    .in_last_i    (in_last_i),
    .rail_count_i (rail_count_q),
    .decrypt_i    (decrypt_mode_q),
    .out_valid_o  (out_valid_o),
    .out_byte_o   (out_byte_o),
    .out_last_o   (out_last_o),
    .overflow_o   (overflow_o)
  );

endmodule
